// File: rtl/ews_pkg.sv
package ews_pkg;

	typedef logic signed [7:0]  speed_t;
	typedef logic signed [15:0] count_t;

	typedef enum logic [1:0] {
		FUNC_TICK       = 2'd0,
		FUNC_EDGE_LEFT  = 2'd1,
		FUNC_EDGE_RIGHT = 2'd2,
		FUNC_COMMAND    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_ENCODER_GAIN = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_MAX_SPEED    = 3'd3,
		REG_TICK_DIVIDER = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL_L,
		S_DIV_L,
		S_MUL_R,
		S_DIV_R,
		S_MUL_P,
		S_DIV_P,
		S_MUL_I,
		S_DIV_I,
		S_DRIVE,
		S_PUBLISH
	} state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_FIX
	} div_state_t;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam int DIV_DIVIDEND_W     = 32;
	localparam int DIV_DIVISOR_W      = 11;
	localparam int DIV_BITS_PER_CYCLE = 2;
	localparam int QUOT_W             = 16;

	localparam logic signed [DIV_DIVISOR_W-1:0] SCALE_DIV = 11'sd1000;

	localparam logic [7:0] ENC_GAIN_RESET  = 8'd1;
	localparam logic [6:0] MAX_SPEED_RESET = 7'd127;

endpackage

// File: rtl/ews_if.sv
interface ews_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic              sensor_a;
	logic              sensor_b;
	ews_pkg::speed_t   speed_left;
	ews_pkg::speed_t   speed_right;
	ews_pkg::count_t   target_left;
	ews_pkg::count_t   target_right;

	modport source (
		output valid, func, sensor_a, sensor_b, speed_left, speed_right,
		       target_left, target_right,
		input  ready
	);
	modport sink (
		input  valid, func, sensor_a, sensor_b, speed_left, speed_right,
		       target_left, target_right,
		output ready
	);
endinterface

interface ews_out_if;
	logic              valid;
	logic              ready;
	ews_pkg::speed_t   drive_left;
	ews_pkg::speed_t   drive_right;
	logic              target_hit;
	ews_pkg::count_t   count_left;
	ews_pkg::count_t   count_right;

	modport source (
		output valid, drive_left, drive_right, target_hit, count_left, count_right,
		input  ready
	);
	modport sink (
		input  valid, drive_left, drive_right, target_hit, count_left, count_right,
		output ready
	);
endinterface

// File: rtl/ews_div.sv
module ews_div (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic signed [ews_pkg::DIV_DIVIDEND_W-1:0]  dividend,
	input  logic signed [ews_pkg::DIV_DIVISOR_W-1:0]   divisor,
	output logic                                       done,
	output logic signed [ews_pkg::QUOT_W-1:0]          quotient
);

	localparam int W     = ews_pkg::DIV_DIVIDEND_W;
	localparam int DW    = ews_pkg::DIV_DIVISOR_W;
	localparam int QW    = ews_pkg::QUOT_W;
	localparam int BPC   = ews_pkg::DIV_BITS_PER_CYCLE;
	localparam int ITER  = W / BPC;
	localparam int CNT_W = $clog2(ITER);

	ews_pkg::div_state_t state_q, state_n;

	logic [W-1:0]     work_q, work_n, dend_mag;
	logic [DW-1:0]    rem_q, rem_n, dmag_q, dsor_mag;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QW-1:0]    quot_q;
	logic             done_q;

	assign dend_mag = dividend[W-1] ? $unsigned(-dividend) : $unsigned(dividend);
	assign dsor_mag = divisor[DW-1] ? $unsigned(-divisor) : $unsigned(divisor);

	// Restoring division, several quotient bits per cycle on magnitudes.
	always_comb begin
		logic [DW-1:0] rem_v;
		logic [W-1:0]  work_v;
		logic [DW:0]   trial;
		rem_v  = rem_q;
		work_v = work_q;
		for (int k = 0; k < BPC; k++) begin
			trial  = {rem_v, work_v[W-1]};
			work_v = {work_v[W-2:0], 1'b0};
			if (trial >= {1'b0, dmag_q}) begin
				trial     = trial - {1'b0, dmag_q};
				work_v[0] = 1'b1;
			end
			rem_v = trial[DW-1:0];
		end
		rem_n  = rem_v;
		work_n = work_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ews_pkg::DIV_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ews_pkg::DIV_IDLE: begin
				if (start) state_n = ews_pkg::DIV_RUN;
			end
			ews_pkg::DIV_RUN: begin
				if (cnt_q == CNT_W'(ITER - 1)) state_n = ews_pkg::DIV_FIX;
			end
			ews_pkg::DIV_FIX: begin
				state_n = ews_pkg::DIV_IDLE;
			end
			default: begin
				state_n = ews_pkg::DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ews_pkg::DIV_FIX);
			if (state_q == ews_pkg::DIV_IDLE && start) begin
				cnt_q <= '0;
			end else if (state_q == ews_pkg::DIV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ews_pkg::DIV_IDLE && start) begin
			work_q <= dend_mag;
			rem_q  <= '0;
			dmag_q <= dsor_mag;
			neg_q  <= dividend[W-1] ^ divisor[DW-1];
		end else if (state_q == ews_pkg::DIV_RUN) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
		if (state_q == ews_pkg::DIV_FIX) begin
			quot_q <= neg_q ? (~work_q[QW-1:0] + 1'b1) : work_q[QW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// File: rtl/encoder_wheel_sync_controller.sv
// Two-wheel drive controller: encoder edge requests move a 16-bit wheel count, command
// requests load speeds and count targets, and tick requests check the targets and run the
// PI wheel balancing step. One request is in work at a time. Edge, command and plain tick
// requests go from the decode state straight to the publish state. A tick that runs the PI
// step uses the shared 16 by 16 multiplier and the shared serial divider, which is used four
// times per step at two quotient bits a cycle; each use is a multiplier state followed by a
// divider state that waits for the divider to finish. A finished result waits in the output
// register while the next request is accepted; input stalls while a request is in work, and
// a request cannot be published while a further result is still waiting.
module encoder_wheel_sync_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	ews_in_if.sink                           item,
	ews_out_if.source                        result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ews_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ews_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ews_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	ews_pkg::state_t state_q, state_n;

	logic [7:0]      enc_gain_q;
	ews_pkg::count_t gain_p_q;
	ews_pkg::count_t gain_i_q;
	logic [6:0]      max_speed_q;
	logic [15:0]     tick_div_q;

	ews_pkg::count_t left_count_q, right_count_q, left_prev_q, right_prev_q;
	logic [15:0]     tick_count_q;
	ews_pkg::count_t integral_q;
	ews_pkg::speed_t speed_l_q, speed_r_q, drive_l_q, drive_r_q;
	ews_pkg::count_t target_l_q, target_r_q;
	logic            hit_q;

	logic [1:0]      func_q;
	logic            same_q;
	ews_pkg::speed_t cmd_speed_l_q, cmd_speed_r_q;
	ews_pkg::count_t cmd_target_l_q, cmd_target_r_q;

	logic signed [31:0] prod_q, product;
	ews_pkg::count_t    mul_a, mul_b;
	ews_pkg::count_t    quot_l_q, err_q, p_q;
	logic               start_q;
	logic signed [ews_pkg::DIV_DIVISOR_W-1:0] divisor;
	logic               div_done;
	ews_pkg::count_t    div_quot;

	ews_pkg::speed_t res_drive_l_q, res_drive_r_q;
	logic            res_hit_q;
	ews_pkg::count_t res_count_l_q, res_count_r_q;
	logic            res_valid_q;

	logic            accept, pub_fire, hit_now, speeds_on, pi_go, cfg_write;
	ews_pkg::count_t dl, dr, sum_r, sum_l;

	function automatic logic reached(input ews_pkg::count_t t, input ews_pkg::count_t c);
		return (t > 0 && c >= t) || (t < 0 && c <= t);
	endfunction

	function automatic ews_pkg::speed_t clamp_drive(input ews_pkg::count_t v,
	                                                input logic [6:0] lim);
		ews_pkg::count_t hi, lo;
		hi = $signed({9'b0, lim});
		lo = -hi;
		if (v > hi) return hi[7:0];
		else if (v < lo) return lo[7:0];
		else return v[7:0];
	endfunction

	assign accept    = item.valid && item.ready;
	assign hit_now   = reached(target_r_q, right_count_q) || reached(target_l_q, left_count_q);
	assign speeds_on = (speed_l_q != 0) && (speed_r_q != 0);
	assign pi_go     = (func_q == ews_pkg::FUNC_TICK) && !hit_now && speeds_on &&
	                   (tick_count_q >= tick_div_q);
	assign dl        = left_count_q - left_prev_q;
	assign dr        = right_count_q - right_prev_q;
	assign sum_r     = 16'(speed_r_q) + p_q + integral_q;
	assign sum_l     = 16'(speed_l_q) - p_q - integral_q;

	always_comb begin
		case (state_q)
			ews_pkg::S_MUL_R: begin
				mul_a = dr;
				mul_b = $signed({8'b0, enc_gain_q});
			end
			ews_pkg::S_MUL_P: begin
				mul_a = err_q;
				mul_b = gain_p_q;
			end
			ews_pkg::S_MUL_I: begin
				mul_a = err_q;
				mul_b = gain_i_q;
			end
			default: begin
				mul_a = dl;
				mul_b = $signed({8'b0, enc_gain_q});
			end
		endcase
	end

	assign product = mul_a * mul_b;

	always_comb begin
		case (state_q)
			ews_pkg::S_DIV_L: divisor = ews_pkg::DIV_DIVISOR_W'(speed_l_q);
			ews_pkg::S_DIV_R: divisor = ews_pkg::DIV_DIVISOR_W'(speed_r_q);
			default:          divisor = ews_pkg::SCALE_DIV;
		endcase
	end

	ews_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (prod_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ews_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n    = state_q;
		item.ready = 1'b0;
		pub_fire   = 1'b0;
		case (state_q)
			ews_pkg::S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) state_n = ews_pkg::S_DECODE;
			end
			ews_pkg::S_DECODE: begin
				state_n = pi_go ? ews_pkg::S_MUL_L : ews_pkg::S_PUBLISH;
			end
			ews_pkg::S_MUL_L: state_n = ews_pkg::S_DIV_L;
			ews_pkg::S_DIV_L: begin
				if (div_done) state_n = ews_pkg::S_MUL_R;
			end
			ews_pkg::S_MUL_R: state_n = ews_pkg::S_DIV_R;
			ews_pkg::S_DIV_R: begin
				if (div_done) state_n = ews_pkg::S_MUL_P;
			end
			ews_pkg::S_MUL_P: state_n = ews_pkg::S_DIV_P;
			ews_pkg::S_DIV_P: begin
				if (div_done) state_n = ews_pkg::S_MUL_I;
			end
			ews_pkg::S_MUL_I: state_n = ews_pkg::S_DIV_I;
			ews_pkg::S_DIV_I: begin
				if (div_done) state_n = ews_pkg::S_DRIVE;
			end
			ews_pkg::S_DRIVE: state_n = ews_pkg::S_PUBLISH;
			ews_pkg::S_PUBLISH: begin
				if (!res_valid_q || result.ready) begin
					pub_fire = 1'b1;
					state_n  = ews_pkg::S_IDLE;
				end
			end
			default: state_n = ews_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_count_q  <= '0;
			right_count_q <= '0;
			left_prev_q   <= '0;
			right_prev_q  <= '0;
			tick_count_q  <= '0;
			integral_q    <= '0;
			speed_l_q     <= '0;
			speed_r_q     <= '0;
			target_l_q    <= '0;
			target_r_q    <= '0;
			drive_l_q     <= '0;
			drive_r_q     <= '0;
			hit_q         <= 1'b0;
			start_q       <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			start_q <= (state_q == ews_pkg::S_MUL_L) || (state_q == ews_pkg::S_MUL_R) ||
			           (state_q == ews_pkg::S_MUL_P) || (state_q == ews_pkg::S_MUL_I);

			if (pub_fire) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;

			case (state_q)
				ews_pkg::S_DECODE: begin
					hit_q <= 1'b0;
					case (func_q)
						ews_pkg::FUNC_TICK: begin
							if (hit_now) begin
								// Stopping on a target leaves the drives at zero.
								hit_q        <= 1'b1;
								speed_l_q    <= '0;
								speed_r_q    <= '0;
								target_l_q   <= '0;
								target_r_q   <= '0;
								drive_l_q    <= '0;
								drive_r_q    <= '0;
								left_prev_q  <= left_count_q;
								right_prev_q <= right_count_q;
							end else if (speeds_on) begin
								if (tick_count_q >= tick_div_q) tick_count_q <= '0;
								else tick_count_q <= tick_count_q + 1'b1;
							end else begin
								left_prev_q  <= left_count_q;
								right_prev_q <= right_count_q;
								drive_l_q    <= speed_l_q;
								drive_r_q    <= speed_r_q;
							end
						end
						ews_pkg::FUNC_EDGE_LEFT: begin
							left_count_q <= same_q ? left_count_q + 16'sd1
							                       : left_count_q - 16'sd1;
						end
						ews_pkg::FUNC_EDGE_RIGHT: begin
							right_count_q <= same_q ? right_count_q + 16'sd1
							                        : right_count_q - 16'sd1;
						end
						default: begin
							speed_l_q  <= cmd_speed_l_q;
							speed_r_q  <= cmd_speed_r_q;
							target_l_q <= cmd_target_l_q;
							target_r_q <= cmd_target_r_q;
						end
					endcase
				end
				ews_pkg::S_DIV_I: begin
					if (div_done) integral_q <= integral_q + div_quot;
				end
				ews_pkg::S_DRIVE: begin
					drive_r_q    <= clamp_drive(sum_r, max_speed_q);
					drive_l_q    <= clamp_drive(sum_l, max_speed_q);
					left_prev_q  <= left_count_q;
					right_prev_q <= right_count_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q         <= item.func;
			same_q         <= (item.sensor_a == item.sensor_b);
			cmd_speed_l_q  <= item.speed_left;
			cmd_speed_r_q  <= item.speed_right;
			cmd_target_l_q <= item.target_left;
			cmd_target_r_q <= item.target_right;
		end
		if ((state_q == ews_pkg::S_MUL_L) || (state_q == ews_pkg::S_MUL_R) ||
		    (state_q == ews_pkg::S_MUL_P) || (state_q == ews_pkg::S_MUL_I)) begin
			prod_q <= product;
		end
		if (div_done) begin
			case (state_q)
				ews_pkg::S_DIV_L: quot_l_q <= div_quot;
				ews_pkg::S_DIV_R: err_q    <= quot_l_q - div_quot;
				ews_pkg::S_DIV_P: p_q      <= div_quot;
				default: begin
				end
			endcase
		end
		if (pub_fire) begin
			res_drive_l_q <= drive_l_q;
			res_drive_r_q <= drive_r_q;
			res_hit_q     <= hit_q;
			res_count_l_q <= left_count_q;
			res_count_r_q <= right_count_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.drive_left  = res_drive_l_q;
	assign result.drive_right = res_drive_r_q;
	assign result.target_hit  = res_hit_q;
	assign result.count_left  = res_count_l_q;
	assign result.count_right = res_count_r_q;

	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_gain_q  <= ews_pkg::ENC_GAIN_RESET;
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			max_speed_q <= ews_pkg::MAX_SPEED_RESET;
			tick_div_q  <= '0;
		end else if (cfg_write) begin
			case (paddr[4:2])
				ews_pkg::REG_ENCODER_GAIN: enc_gain_q  <= pwdata[7:0];
				ews_pkg::REG_GAIN_P:       gain_p_q    <= pwdata[15:0];
				ews_pkg::REG_GAIN_I:       gain_i_q    <= pwdata[15:0];
				ews_pkg::REG_MAX_SPEED:    max_speed_q <= pwdata[6:0];
				ews_pkg::REG_TICK_DIVIDER: tick_div_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ews_pkg::REG_ENCODER_GAIN: prdata = {24'b0, enc_gain_q};
			ews_pkg::REG_GAIN_P:       prdata = {16'b0, gain_p_q};
			ews_pkg::REG_GAIN_I:       prdata = {16'b0, gain_i_q};
			ews_pkg::REG_MAX_SPEED:    prdata = {25'b0, max_speed_q};
			ews_pkg::REG_TICK_DIVIDER: prdata = {16'b0, tick_div_q};
			default:                   prdata = '0;
		endcase
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int PERMILLE        = 1000;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 100;

	typedef struct packed {
		ews_pkg::func_t  func;
		logic            sa;
		logic            sb;
		ews_pkg::speed_t spd_l;
		ews_pkg::speed_t spd_r;
		ews_pkg::count_t tgt_l;
		ews_pkg::count_t tgt_r;
	} wheel_req_t;

	typedef struct packed {
		ews_pkg::speed_t drv_l;
		ews_pkg::speed_t drv_r;
		logic            hit;
		ews_pkg::count_t cnt_l;
		ews_pkg::count_t cnt_r;
	} wheel_status_t;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ews_pkg::APB_ADDR_W-1:0] paddr;
	logic [ews_pkg::APB_DATA_W-1:0] pwdata;
	logic [ews_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	ews_in_if  item_bus ();
	ews_out_if result_bus ();

	encoder_wheel_sync_controller u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted controller state and register settings.
	ews_pkg::count_t enc_l, enc_r, prev_l, prev_r;
	logic [15:0]     skip_cnt;
	ews_pkg::count_t integ;
	ews_pkg::speed_t spd [2];
	ews_pkg::count_t tgt [2];
	ews_pkg::speed_t drv [2];
	logic [7:0]      cfg_gain;
	ews_pkg::count_t cfg_kp, cfg_ki;
	logic [6:0]      cfg_max;
	logic [15:0]     cfg_div;

	wheel_status_t expected_status [$];
	int            mismatches = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	int            hold_off_requests = 0;
	bit            heading_up = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_predictor();
		enc_l    = '0;
		enc_r    = '0;
		prev_l   = '0;
		prev_r   = '0;
		skip_cnt = '0;
		integ    = '0;
		spd      = '{default: '0};
		tgt      = '{default: '0};
		drv      = '{default: '0};
		cfg_gain = ews_pkg::ENC_GAIN_RESET;
		cfg_kp   = '0;
		cfg_ki   = '0;
		cfg_max  = ews_pkg::MAX_SPEED_RESET;
		cfg_div  = '0;
	endfunction

	function automatic int wrap16(input int v);
		ews_pkg::count_t w;
		w = v[15:0];
		return int'(w);
	endfunction

	function automatic ews_pkg::speed_t limit_drive(input int v);
		int m;
		m = int'(cfg_max);
		if (v > m)
			return ews_pkg::speed_t'(m);
		if (v < -m)
			return ews_pkg::speed_t'(-m);
		return ews_pkg::speed_t'(v);
	endfunction

	function automatic bit target_reached(input ews_pkg::count_t target,
			input ews_pkg::count_t cnt);
		return (target > 0 && cnt >= target) || (target < 0 && cnt <= target);
	endfunction

	function automatic wheel_status_t predict_wheel_status(input wheel_req_t r);
		wheel_status_t s;
		int dl, dr, ql, qr, err, kp_term, sl, sr;
		s.hit = 1'b0;
		case (r.func)
			ews_pkg::FUNC_TICK: begin
				if (tgt[0] != 0 || tgt[1] != 0) begin
					if (target_reached(tgt[1], enc_r) || target_reached(tgt[0], enc_l)) begin
						drv   = '{default: '0};
						spd   = '{default: '0};
						tgt   = '{default: '0};
						s.hit = 1'b1;
					end
				end
				if (spd[0] != 0 && spd[1] != 0) begin
					if (skip_cnt >= cfg_div) begin
						skip_cnt = '0;
						dl       = wrap16(int'(enc_l) - int'(prev_l));
						dr       = wrap16(int'(enc_r) - int'(prev_r));
						ql       = (dl * int'(cfg_gain)) / int'(spd[0]);
						qr       = (dr * int'(cfg_gain)) / int'(spd[1]);
						err      = wrap16(ql - qr);
						kp_term  = wrap16((err * int'(cfg_kp)) / PERMILLE);
						integ    = ews_pkg::count_t'(wrap16(int'(integ) +
						           (err * int'(cfg_ki)) / PERMILLE));
						sr       = wrap16(int'(spd[1]) + kp_term + int'(integ));
						sl       = wrap16(int'(spd[0]) - kp_term - int'(integ));
						drv[1]   = limit_drive(sr);
						drv[0]   = limit_drive(sl);
						prev_r   = enc_r;
						prev_l   = enc_l;
					end else begin
						skip_cnt = skip_cnt + 16'd1;
					end
				end else begin
					prev_l = enc_l;
					prev_r = enc_r;
					drv[0] = spd[0];
					drv[1] = spd[1];
				end
			end
			ews_pkg::FUNC_EDGE_LEFT: begin
				enc_l = (r.sa == r.sb) ? enc_l + 16'd1 : enc_l - 16'd1;
			end
			ews_pkg::FUNC_EDGE_RIGHT: begin
				enc_r = (r.sa == r.sb) ? enc_r + 16'd1 : enc_r - 16'd1;
			end
			default: begin
				spd[0] = r.spd_l;
				spd[1] = r.spd_r;
				tgt[0] = r.tgt_l;
				tgt[1] = r.tgt_r;
			end
		endcase
		s.drv_l = drv[0];
		s.drv_r = drv[1];
		s.cnt_l = enc_l;
		s.cnt_r = enc_r;
		return s;
	endfunction

	function automatic wheel_req_t noisy_request(input ews_pkg::func_t f);
		wheel_req_t r;
		r.func  = f;
		r.sa    = 1'($urandom_range(1));
		r.sb    = 1'($urandom_range(1));
		r.spd_l = ews_pkg::speed_t'($urandom);
		r.spd_r = ews_pkg::speed_t'($urandom);
		r.tgt_l = ews_pkg::count_t'($urandom);
		r.tgt_r = ews_pkg::count_t'($urandom);
		return r;
	endfunction

	function automatic wheel_req_t random_wheel_request();
		wheel_req_t r;
		int pick, k;
		pick = int'($urandom_range(99));
		if (pick < 45) begin
			r = noisy_request(ews_pkg::func_t'($urandom_range(1) ? ews_pkg::FUNC_EDGE_LEFT
			                                                     : ews_pkg::FUNC_EDGE_RIGHT));
			if (pick < 38)
				r.sb = heading_up ? r.sa : ~r.sa;
		end else if (pick < 82) begin
			r = noisy_request(ews_pkg::FUNC_TICK);
		end else begin
			r = noisy_request(ews_pkg::FUNC_COMMAND);
			if (pick < 95) begin
				heading_up = 1'($urandom_range(1));
				k          = int'($urandom_range(127, 1));
				r.spd_l    = ews_pkg::speed_t'($urandom_range(1) ? k : -k);
				k          = int'($urandom_range(127, 1));
				r.spd_r    = ews_pkg::speed_t'(($urandom_range(9) == 0) ? 0
				             : ($urandom_range(1) ? k : -k));
				k          = int'($urandom_range(25, 1));
				r.tgt_l    = ews_pkg::count_t'(int'(enc_l) + (heading_up ? k : -k));
				k          = int'($urandom_range(25, 1));
				r.tgt_r    = ews_pkg::count_t'(int'(enc_r) + (heading_up ? k : -k));
				case ($urandom_range(3))
					0: begin
						r.tgt_l = '0;
						r.tgt_r = '0;
					end
					1: r.tgt_r = '0;
					2: r.tgt_l = '0;
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	task automatic send_request(input wheel_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid        <= 1'b1;
		item_bus.func         <= r.func;
		item_bus.sensor_a     <= r.sa;
		item_bus.sensor_b     <= r.sb;
		item_bus.speed_left   <= r.spd_l;
		item_bus.speed_right  <= r.spd_r;
		item_bus.target_left  <= r.tgt_l;
		item_bus.target_right <= r.tgt_r;
		do
			@(posedge clk);
		while (!item_bus.ready);
		expected_status.push_back(predict_wheel_status(r));
	endtask

	task automatic send_tick();
		send_request(noisy_request(ews_pkg::FUNC_TICK));
	endtask

	task automatic send_edge(input ews_pkg::func_t side, input logic sa, input logic sb);
		wheel_req_t r;
		r    = noisy_request(side);
		r.sa = sa;
		r.sb = sb;
		send_request(r);
	endtask

	task automatic send_command(input int sl, input int sr, input int tl, input int tr);
		wheel_req_t r;
		r       = noisy_request(ews_pkg::FUNC_COMMAND);
		r.spd_l = ews_pkg::speed_t'(sl);
		r.spd_r = ews_pkg::speed_t'(sr);
		r.tgt_l = ews_pkg::count_t'(tl);
		r.tgt_r = ews_pkg::count_t'(tr);
		send_request(r);
	endtask

	task automatic settle();
		item_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_status.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	task automatic check_register(input ews_pkg::reg_idx_t idx);
		logic [31:0] got, want, mask;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			ews_pkg::REG_ENCODER_GAIN: begin
				want = 32'(cfg_gain);
				mask = 32'h0000_00ff;
			end
			ews_pkg::REG_GAIN_P: begin
				want = 32'(unsigned'(cfg_kp));
				mask = 32'h0000_ffff;
			end
			ews_pkg::REG_GAIN_I: begin
				want = 32'(unsigned'(cfg_ki));
				mask = 32'h0000_ffff;
			end
			ews_pkg::REG_MAX_SPEED: begin
				want = 32'(cfg_max);
				mask = 32'h0000_007f;
			end
			default: begin
				want = 32'(cfg_div);
				mask = 32'h0000_ffff;
			end
		endcase
		compare_field(idx.name(), int'(want), int'(got & mask));
	endtask

	task automatic write_register(input ews_pkg::reg_idx_t idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			ews_pkg::REG_ENCODER_GAIN: cfg_gain = value[7:0];
			ews_pkg::REG_GAIN_P:       cfg_kp   = value[15:0];
			ews_pkg::REG_GAIN_I:       cfg_ki   = value[15:0];
			ews_pkg::REG_MAX_SPEED:    cfg_max  = value[6:0];
			default:                   cfg_div  = value[15:0];
		endcase
		check_register(idx);
	endtask

	task automatic apply_settings(input int gain, input int kp, input int ki, input int maxs,
			input int div);
		settle();
		write_register(ews_pkg::REG_ENCODER_GAIN, gain);
		write_register(ews_pkg::REG_GAIN_P, kp);
		write_register(ews_pkg::REG_GAIN_I, ki);
		write_register(ews_pkg::REG_MAX_SPEED, maxs);
		write_register(ews_pkg::REG_TICK_DIVIDER, div);
	endtask

	task automatic test_register_access();
		for (int i = int'(ews_pkg::REG_ENCODER_GAIN); i <= int'(ews_pkg::REG_TICK_DIVIDER); i++)
			check_register(ews_pkg::reg_idx_t'(i));
		apply_settings(255, 32767, -32768, 0, 65535);
		apply_settings(0, -32768, 32767, 127, 0);
		apply_settings(int'(ews_pkg::ENC_GAIN_RESET), 0, 0, int'(ews_pkg::MAX_SPEED_RESET), 0);
	endtask

	task automatic test_encoder_edges();
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b0, 1'b0);
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b1, 1'b0);
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b0, 1'b1);
		send_edge(ews_pkg::FUNC_EDGE_RIGHT, 1'b1, 1'b1);
		send_tick();
	endtask

	// The drives only follow a command on the next tick; a speed of -128 is copied as is.
	task automatic test_command_timing();
		send_command(-128, 0, 0, 0);
		send_tick();
		send_command(127, -127, 32767, -32768);
		send_tick();
	endtask

	task automatic test_target_stop();
		send_command(50, 60, 2, 0);
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b0, 1'b0);
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b1, 1'b1);
		send_tick();
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b1, 1'b1);
		send_tick();
		send_command(-30, 40, 0, -1);
		send_edge(ews_pkg::FUNC_EDGE_RIGHT, 1'b0, 1'b1);
		send_edge(ews_pkg::FUNC_EDGE_RIGHT, 1'b1, 1'b0);
		send_tick();
	endtask

	task automatic test_pi_arithmetic();
		apply_settings(255, 32767, 32767, 127, 1);
		send_command(1, -1, 0, 0);
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b1, 1'b1);
		send_tick();
		send_tick();
		send_edge(ews_pkg::FUNC_EDGE_LEFT, 1'b0, 1'b0);
		send_tick();
		send_tick();
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
			input int count);
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		for (int i = 0; i < count; i++)
			send_request(random_wheel_request());
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_requests++;
		for (int i = 0; i < 30; i++)
			send_request(random_wheel_request());
	endtask

	initial begin : receiver
		int            hold_left;
		int            hold_served;
		wheel_status_t want;
		hold_left        = 0;
		hold_served      = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				if (expected_status.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					compare_field("drive_left", int'(want.drv_l), int'(result_bus.drive_left));
					compare_field("drive_right", int'(want.drv_r),
						int'(result_bus.drive_right));
					compare_field("target_hit", int'(want.hit), int'(result_bus.target_hit));
					compare_field("count_left", int'(want.cnt_l), int'(result_bus.count_left));
					compare_field("count_right", int'(want.cnt_r),
						int'(result_bus.count_right));
				end
			end
			if (hold_served != hold_off_requests) begin
				hold_served = hold_off_requests;
				hold_left   = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
					|| psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		item_bus.valid        <= 1'b0;
		item_bus.func         <= ews_pkg::FUNC_TICK;
		item_bus.sensor_a     <= 1'b0;
		item_bus.sensor_b     <= 1'b0;
		item_bus.speed_left   <= '0;
		item_bus.speed_right  <= '0;
		item_bus.target_left  <= '0;
		item_bus.target_right <= '0;
		reset_predictor();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 74;
		test_register_access();
		test_encoder_edges();
		test_command_timing();
		test_target_stop();
		test_pi_arithmetic();

		apply_settings(1, 800, 150, 127, 0);
		test_random_traffic(26, 74, 120);
		apply_settings(255, 32767, -32768, 0, 2);
		test_random_traffic(74, 26, 120);
		apply_settings(0, -32768, 32767, 127, 65535);
		test_random_traffic(0, 0, 120);
		apply_settings(23, -1500, 40, 90, 1);
		test_random_traffic(0, 0, 120);
		test_output_backpressure();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/ews_pkg.sv
rtl/ews_if.sv
rtl/ews_div.sv
rtl/encoder_wheel_sync_controller.sv
tb/tb_top.sv
